FILE: rtl/staged_fire_alert_escalation_defines.svh
// ----------------------------------------------------------------------------
// Staged fire alert escalation: assertion macros
// Shared concurrent assertion forms for the escalation block.
// ----------------------------------------------------------------------------
`ifndef STAGED_FIRE_ALERT_ESCALATION_DEFINES_SVH
`define STAGED_FIRE_ALERT_ESCALATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfae: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SFAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfae: next-cycle check failed");

`endif

FILE: rtl/sfae_pkg.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: package
// Register map, reset values, conversion constants and shared structs.
// ----------------------------------------------------------------------------
package sfae_pkg;

    // Configuration port geometry
    localparam int unsigned CfgAddrWidth = 5;
    localparam int unsigned CfgDataWidth = 32;

    // Register indexes, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_TEMP_LIMIT      = 3'd0,
        REG_HUMIDITY_LIMIT  = 3'd1,
        REG_CO_LIMIT        = 3'd2,
        REG_SMOKE_LIMIT     = 3'd3,
        REG_NORMAL_INTERVAL = 3'd4,
        REG_ALERT_INTERVAL  = 3'd5,
        REG_HOLDOFF         = 3'd6,
        REG_SMOKE_TARGET    = 3'd7
    } reg_idx_t;

    // Register reset values
    localparam logic [14:0] TempLimitRst      = 15'd3500;
    localparam logic [13:0] HumidityLimitRst  = 14'd3000;
    localparam logic [15:0] CoLimitRst        = 16'd100;
    localparam logic [15:0] SmokeLimitRst     = 16'd300;
    localparam logic [19:0] NormalIntervalRst = 20'd120000;
    localparam logic [19:0] AlertIntervalRst  = 20'd30000;
    localparam logic [19:0] HoldoffRst        = 20'd300000;
    localparam logic [2:0]  SmokeTargetRst    = 3'd3;

    // CO sensor conversion: millivolts at full scale and map break points
    localparam logic [23:0] MvFullScale = 24'd3300;
    localparam logic [15:0] MvKnee0     = 16'd600;
    localparam logic [15:0] MvKnee1     = 16'd1000;
    localparam logic [15:0] MvKnee2     = 16'd2000;
    localparam logic [15:0] MvKnee3     = 16'd3000;
    localparam logic [15:0] PpmFloor    = 16'd50;
    localparam logic [15:0] PpmKnee1    = 16'd500;
    localparam logic [15:0] PpmKnee2    = 16'd5000;
    localparam logic [15:0] PpmCeiling  = 16'd50000;

    // Configuration as seen by the evaluation logic
    typedef struct packed {
        logic [14:0] temp_limit_centi;
        logic [13:0] humidity_limit_centi;
        logic [15:0] co_limit_tenths;
        logic [15:0] smoke_limit;
        logic [19:0] normal_interval_ms;
        logic [19:0] alert_interval_ms;
        logic [19:0] holdoff_ms;
        logic [2:0]  smoke_target;
    } cfg_t;

    // One converted item presented to the evaluation logic
    typedef struct packed {
        logic [31:0] now_ms;
        logic [14:0] temperature_centi;
        logic [13:0] humidity_centi;
        logic [15:0] co_ppm_tenths;
        logic [15:0] pm25_level;
    } eval_item_t;

    // One result item
    typedef struct packed {
        logic        evaluated;
        logic        env_alarm;
        logic        co_alarm;
        logic        critical;
        logic [2:0]  smoke_count;
        logic [15:0] co_ppm_tenths;
        logic [19:0] interval_now_ms;
        logic        holding_off;
    } result_t;

endpackage

FILE: rtl/sfae_if.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: channel interfaces
// Valid/ready channels for sensor snapshots and alert status results.
// ----------------------------------------------------------------------------

// Sensor snapshot channel
interface sfae_sensor_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic signed [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic [11:0] co_adc_level;
    logic [15:0] pm25_level;

    modport source (
        output valid, now_ms, temperature_centi, humidity_centi, co_adc_level, pm25_level,
        input  ready
    );
    modport sink (
        input  valid, now_ms, temperature_centi, humidity_centi, co_adc_level, pm25_level,
        output ready
    );
endinterface

// Alert status channel
interface sfae_status_if;
    logic        valid;
    logic        ready;
    logic        evaluated;
    logic        env_alarm;
    logic        co_alarm;
    logic        critical;
    logic [2:0]  smoke_count;
    logic [15:0] co_ppm_tenths;
    logic [19:0] interval_now_ms;
    logic        holding_off;

    modport source (
        output valid, evaluated, env_alarm, co_alarm, critical, smoke_count,
               co_ppm_tenths, interval_now_ms, holding_off,
        input  ready
    );
    modport sink (
        input  valid, evaluated, env_alarm, co_alarm, critical, smoke_count,
               co_ppm_tenths, interval_now_ms, holding_off,
        output ready
    );
endinterface

FILE: rtl/sfae_cfg.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: configuration registers
// APB-style register file holding the alert limits and intervals.
// ----------------------------------------------------------------------------
module sfae_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfae_pkg::CfgAddrWidth-1:0]   paddr,
    input  logic [sfae_pkg::CfgDataWidth-1:0]   pwdata,
    output logic [sfae_pkg::CfgDataWidth-1:0]   prdata,
    output logic                                pready,
    output sfae_pkg::cfg_t                      cfg
);

    sfae_pkg::cfg_t     cfg_reg;
    sfae_pkg::cfg_t     cfg_next;
    sfae_pkg::reg_idx_t reg_idx;
    logic               write_en;

    assign reg_idx  = sfae_pkg::reg_idx_t'(paddr[4:2]);
    assign write_en = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign cfg      = cfg_reg;

    // Write decode: the addressed register takes the low bits of pwdata.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_idx)
                sfae_pkg::REG_TEMP_LIMIT:      cfg_next.temp_limit_centi     = pwdata[14:0];
                sfae_pkg::REG_HUMIDITY_LIMIT:  cfg_next.humidity_limit_centi = pwdata[13:0];
                sfae_pkg::REG_CO_LIMIT:        cfg_next.co_limit_tenths      = pwdata[15:0];
                sfae_pkg::REG_SMOKE_LIMIT:     cfg_next.smoke_limit          = pwdata[15:0];
                sfae_pkg::REG_NORMAL_INTERVAL: cfg_next.normal_interval_ms   = pwdata[19:0];
                sfae_pkg::REG_ALERT_INTERVAL:  cfg_next.alert_interval_ms    = pwdata[19:0];
                sfae_pkg::REG_HOLDOFF:         cfg_next.holdoff_ms           = pwdata[19:0];
                sfae_pkg::REG_SMOKE_TARGET:    cfg_next.smoke_target         = pwdata[2:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit_centi     <= sfae_pkg::TempLimitRst;
            cfg_reg.humidity_limit_centi <= sfae_pkg::HumidityLimitRst;
            cfg_reg.co_limit_tenths      <= sfae_pkg::CoLimitRst;
            cfg_reg.smoke_limit          <= sfae_pkg::SmokeLimitRst;
            cfg_reg.normal_interval_ms   <= sfae_pkg::NormalIntervalRst;
            cfg_reg.alert_interval_ms    <= sfae_pkg::AlertIntervalRst;
            cfg_reg.holdoff_ms           <= sfae_pkg::HoldoffRst;
            cfg_reg.smoke_target         <= sfae_pkg::SmokeTargetRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux: the temperature limit reads back sign-extended.
    always_comb
    begin
        unique case (reg_idx)
            sfae_pkg::REG_TEMP_LIMIT:
                prdata = {{17{cfg_reg.temp_limit_centi[14]}}, cfg_reg.temp_limit_centi};
            sfae_pkg::REG_HUMIDITY_LIMIT:  prdata = {18'd0, cfg_reg.humidity_limit_centi};
            sfae_pkg::REG_CO_LIMIT:        prdata = {16'd0, cfg_reg.co_limit_tenths};
            sfae_pkg::REG_SMOKE_LIMIT:     prdata = {16'd0, cfg_reg.smoke_limit};
            sfae_pkg::REG_NORMAL_INTERVAL: prdata = {12'd0, cfg_reg.normal_interval_ms};
            sfae_pkg::REG_ALERT_INTERVAL:  prdata = {12'd0, cfg_reg.alert_interval_ms};
            sfae_pkg::REG_HOLDOFF:         prdata = {12'd0, cfg_reg.holdoff_ms};
            sfae_pkg::REG_SMOKE_TARGET:    prdata = {29'd0, cfg_reg.smoke_target};
            default:                       prdata = '0;
        endcase
    end

endmodule

FILE: rtl/sfae_core.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: evaluation core
// Holds the alert state and works out the result of one item per cycle; the state moves on only on commit.
// ----------------------------------------------------------------------------
`include "staged_fire_alert_escalation_defines.svh"

module sfae_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfae_pkg::cfg_t       cfg,
    input  sfae_pkg::eval_item_t item,
    input  logic                 commit,
    output sfae_pkg::result_t    result
);

    logic [31:0] last_eval_reg,      last_eval_next;
    logic [19:0] interval_reg,       interval_next;
    logic        env_flag_reg,       env_flag_next;
    logic        co_flag_reg,        co_flag_next;
    logic        smoke_flag_reg,     smoke_flag_next;
    logic [2:0]  smoke_count_reg,    smoke_count_next;
    logic        holdoff_active_reg, holdoff_active_next;
    logic [31:0] holdoff_start_reg,  holdoff_start_next;

    logic [31:0] holdoff_age;
    logic [31:0] since_eval;
    logic        holdoff_over;
    logic        ignore;
    logic        due;
    logic        evaluate;
    logic        env_hit;
    logic        critical;

    // Elapsed-time checks, both modulo 2^32.
    assign holdoff_age  = item.now_ms - holdoff_start_reg;
    assign since_eval   = item.now_ms - last_eval_reg;
    assign holdoff_over = holdoff_age >= {12'd0, cfg.holdoff_ms};
    assign ignore       = holdoff_active_reg && !holdoff_over;
    assign due          = since_eval >= {12'd0, interval_reg};
    assign evaluate     = !ignore && due;

    // Environment condition: hot or dry.
    assign env_hit = ($signed(item.temperature_centi) >= $signed(cfg.temp_limit_centi))
                  || (item.humidity_centi < cfg.humidity_limit_centi);

    // Escalation: environment, then CO, then smoke, then critical.
    always_comb
    begin
        last_eval_next      = last_eval_reg;
        interval_next       = interval_reg;
        env_flag_next       = env_flag_reg;
        co_flag_next        = co_flag_reg;
        smoke_flag_next     = smoke_flag_reg;
        smoke_count_next    = smoke_count_reg;
        holdoff_active_next = ignore;
        holdoff_start_next  = holdoff_start_reg;
        critical            = 1'b0;

        if (evaluate)
        begin
            last_eval_next = item.now_ms;
            if (env_hit)
            begin
                env_flag_next = 1'b1;
                interval_next = cfg.alert_interval_ms;
            end
            if (env_flag_next && (item.co_ppm_tenths >= cfg.co_limit_tenths))
            begin
                co_flag_next = 1'b1;
            end
            if (co_flag_next && (item.pm25_level > cfg.smoke_limit))
            begin
                smoke_count_next = smoke_count_next + 3'd1;
            end
            if (smoke_count_next == cfg.smoke_target)
            begin
                smoke_count_next = 3'd0;
                smoke_flag_next  = 1'b1;
            end
            if (env_flag_next && co_flag_next && smoke_flag_next)
            begin
                critical            = 1'b1;
                env_flag_next       = 1'b0;
                co_flag_next        = 1'b0;
                smoke_flag_next     = 1'b0;
                interval_next       = cfg.normal_interval_ms;
                holdoff_active_next = 1'b1;
                holdoff_start_next  = item.now_ms;
            end
        end
    end

    // Result as seen after this item.
    always_comb
    begin
        result.evaluated       = evaluate;
        result.env_alarm       = env_flag_next;
        result.co_alarm        = co_flag_next;
        result.critical        = critical;
        result.smoke_count     = smoke_count_next;
        result.co_ppm_tenths   = item.co_ppm_tenths;
        result.interval_now_ms = interval_next;
        result.holding_off     = holdoff_active_next;
    end

    // State update on each committed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_eval_reg      <= '0;
            interval_reg       <= sfae_pkg::NormalIntervalRst;
            env_flag_reg       <= 1'b0;
            co_flag_reg        <= 1'b0;
            smoke_flag_reg     <= 1'b0;
            smoke_count_reg    <= '0;
            holdoff_active_reg <= 1'b0;
            holdoff_start_reg  <= '0;
        end
        else if (commit)
        begin
            last_eval_reg      <= last_eval_next;
            interval_reg       <= interval_next;
            env_flag_reg       <= env_flag_next;
            co_flag_reg        <= co_flag_next;
            smoke_flag_reg     <= smoke_flag_next;
            smoke_count_reg    <= smoke_count_next;
            holdoff_active_reg <= holdoff_active_next;
            holdoff_start_reg  <= holdoff_start_next;
        end
    end

    // A critical event clears every alert and starts the hold-off.
    `SFAE_ASSERT_NEXT(a_critical_starts_holdoff, clk, rst_n, commit && critical, holdoff_active_reg && !env_flag_reg && !co_flag_reg && !smoke_flag_reg)
    // An ignored item leaves the evaluation time and smoke counter alone.
    `SFAE_ASSERT_NEXT(a_ignored_keeps_state, clk, rst_n, commit && ignore, $stable(last_eval_reg) && $stable(smoke_count_reg))
    // An evaluation stamps the item's time.
    `SFAE_ASSERT_NEXT(a_eval_stamps_time, clk, rst_n, commit && evaluate, last_eval_reg == $past(item.now_ms))
    // Critical is only reported by an evaluation outside hold-off.
    `SFAE_ASSERT_SAME(a_critical_needs_eval, clk, rst_n, critical, result.evaluated && !ignore)

endmodule

FILE: rtl/staged_fire_alert_escalation.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: top level
// Path: an item passes the stage-one, stage-two and output registers before
// its result is shown; earlier results waiting downstream hold it back.
// Throughput: one item per cycle while status is ready; the three-register
// pipeline keeps accepting while a result waits, if a stage ahead is empty.
// Reset: rst_n clears the pipeline, the alert state and the registers at once.
// ----------------------------------------------------------------------------
module staged_fire_alert_escalation (
    input  logic                                clk,
    input  logic                                rst_n,
    sfae_sensor_if.sink                         sensor,
    sfae_status_if.source                       status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfae_pkg::CfgAddrWidth-1:0]   paddr,
    input  logic [sfae_pkg::CfgDataWidth-1:0]   pwdata,
    output logic [sfae_pkg::CfgDataWidth-1:0]   prdata,
    output logic                                pready
);

    sfae_pkg::cfg_t       cfg;
    sfae_pkg::eval_item_t core_item;
    sfae_pkg::result_t    core_result;

    // Stage one: accepted item
    logic        s1_valid_reg;
    logic [31:0] s1_now_reg;
    logic [14:0] s1_temp_reg;
    logic [13:0] s1_hum_reg;
    logic [11:0] s1_adc_reg;
    logic [15:0] s1_pm_reg;

    // Stage two: CO level in millivolts
    logic        s2_valid_reg;
    logic [31:0] s2_now_reg;
    logic [14:0] s2_temp_reg;
    logic [13:0] s2_hum_reg;
    logic [11:0] s2_mv_reg;
    logic [15:0] s2_pm_reg;

    // Output register
    logic              out_valid_reg;
    sfae_pkg::result_t out_reg;

    logic        adv_out;
    logic        adv2;
    logic        adv1;
    logic [23:0] mv_prod;
    logic [23:0] mv_sum;
    logic [11:0] mv;
    logic [15:0] mv16;
    logic [15:0] ppm_low;
    logic [15:0] ppm_mid;
    logic [15:0] ppm_high;
    logic [15:0] ppm;

    sfae_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Each stage moves when the one after it is empty or moving.
    assign adv_out      = !out_valid_reg || status.ready;
    assign adv2         = !s2_valid_reg || adv_out;
    assign adv1         = !s1_valid_reg || adv2;
    assign sensor.ready = adv1;

    // ADC counts to millivolts: adc * 3300 / 4095, the division done as
    // (x + x/4096 + 1) / 4096, which is exact for this range.
    assign mv_prod = {12'd0, s1_adc_reg} * sfae_pkg::MvFullScale;
    assign mv_sum  = mv_prod + {12'd0, mv_prod[23:12]} + 24'd1;
    assign mv      = mv_sum[23:12];

    // Piecewise-linear CO map in tenths of ppm, floor at 50.
    assign mv16     = {4'd0, s2_mv_reg};
    assign ppm_low  = (((mv16 - sfae_pkg::MvKnee0) * 16'd9) >> 3) + sfae_pkg::PpmFloor;
    assign ppm_mid  = (((mv16 - sfae_pkg::MvKnee1) * 16'd9) >> 1) + sfae_pkg::PpmKnee1;
    assign ppm_high = ((mv16 - sfae_pkg::MvKnee2) * 16'd45) + sfae_pkg::PpmKnee2;

    always_comb
    begin
        priority if (mv16 < sfae_pkg::MvKnee0)
        begin
            ppm = sfae_pkg::PpmFloor;
        end
        else if (mv16 < sfae_pkg::MvKnee1)
        begin
            ppm = ppm_low;
        end
        else if (mv16 < sfae_pkg::MvKnee2)
        begin
            ppm = ppm_mid;
        end
        else if (mv16 < sfae_pkg::MvKnee3)
        begin
            ppm = ppm_high;
        end
        else
        begin
            ppm = sfae_pkg::PpmCeiling;
        end
    end

    always_comb
    begin
        core_item.now_ms            = s2_now_reg;
        core_item.temperature_centi = s2_temp_reg;
        core_item.humidity_centi    = s2_hum_reg;
        core_item.co_ppm_tenths     = ppm;
        core_item.pm25_level        = s2_pm_reg;
    end

    sfae_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (core_item),
        .commit (s2_valid_reg && adv_out),
        .result (core_result)
    );

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= sensor.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv1 && sensor.valid)
        begin
            s1_now_reg  <= sensor.now_ms;
            s1_temp_reg <= sensor.temperature_centi;
            s1_hum_reg  <= sensor.humidity_centi;
            s1_adc_reg  <= sensor.co_adc_level;
            s1_pm_reg   <= sensor.pm25_level;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_now_reg  <= s1_now_reg;
            s2_temp_reg <= s1_temp_reg;
            s2_hum_reg  <= s1_hum_reg;
            s2_mv_reg   <= mv;
            s2_pm_reg   <= s1_pm_reg;
        end
        if (adv_out && s2_valid_reg)
        begin
            out_reg <= core_result;
        end
    end

    // Result channel
    assign status.valid           = out_valid_reg;
    assign status.evaluated       = out_reg.evaluated;
    assign status.env_alarm       = out_reg.env_alarm;
    assign status.co_alarm        = out_reg.co_alarm;
    assign status.critical        = out_reg.critical;
    assign status.smoke_count     = out_reg.smoke_count;
    assign status.co_ppm_tenths   = out_reg.co_ppm_tenths;
    assign status.interval_now_ms = out_reg.interval_now_ms;
    assign status.holding_off     = out_reg.holding_off;

endmodule

FILE: tb/sfae_alert_checker.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: status checker
// Watches the sensor and status channels and the register port, keeps its own
// copy of the alert state and configuration, works out the status due for
// every accepted snapshot and compares each accepted status transfer with the
// oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfae_alert_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    sfae_sensor_if                              sensor,
    sfae_status_if                              status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [sfae_pkg::CfgAddrWidth-1:0]   paddr,
    input  logic [sfae_pkg::CfgDataWidth-1:0]   pwdata,
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  snapshots,
    output int                                  evaluations,
    output int                                  criticals,
    output int                                  held_off
);

    // Mismatch lines beyond this many are counted but not printed.
    localparam int PrintCap = 40;

    // Shadow of the register file and of the escalation state
    sfae_pkg::cfg_t regs;
    logic [31:0]    last_eval_ms;
    logic [19:0]    interval_ms;
    logic           env_on;
    logic           co_on;
    logic           smoke_on;
    logic [2:0]     smoke_cnt;
    logic           holdoff_on;
    logic [31:0]    holdoff_from;

    // Status values owed by the block, oldest first
    sfae_pkg::result_t owed_status[$];
    int                statuses_seen;

    // Piecewise-linear CO map: ADC code to millivolts, then to tenths of ppm.
    function automatic logic [15:0] co_from_adc(input logic [11:0] adc);
        int unsigned mv;
        int unsigned ppm;
        mv = (int'(adc) * 3300) / 4095;
        if (mv < 600)
            ppm = 0;
        else if (mv < 1000)
            ppm = (mv - 600) * 9 / 8 + 50;
        else if (mv < 2000)
            ppm = (mv - 1000) * 9 / 2 + 500;
        else if (mv < 3000)
            ppm = (mv - 2000) * 45 + 5000;
        else
            ppm = 50000;
        if (ppm < 50)
            ppm = 50;
        if (ppm > 50000)
            ppm = 50000;
        return ppm[15:0];
    endfunction

    // Advances the escalation state by one snapshot and returns its status.
    function automatic sfae_pkg::result_t escalate(input logic [31:0] now,
                                                   input logic signed [14:0] temp,
                                                   input logic [13:0] hum,
                                                   input logic [11:0] adc,
                                                   input logic [15:0] pm);
        sfae_pkg::result_t r;
        logic [15:0]       ppm;
        logic              ignore;
        ppm    = co_from_adc(adc);
        r      = '0;
        ignore = 1'b0;

        // A hold-off swallows snapshots until its time has run out.
        if (holdoff_on)
        begin
            if (now - holdoff_from < {12'd0, regs.holdoff_ms})
                ignore = 1'b1;
            else
                holdoff_on = 1'b0;
        end

        if (!ignore && (now - last_eval_ms >= {12'd0, interval_ms}))
        begin
            r.evaluated  = 1'b1;
            last_eval_ms = now;
            if (temp >= $signed(regs.temp_limit_centi) || hum < regs.humidity_limit_centi)
            begin
                env_on      = 1'b1;
                interval_ms = regs.alert_interval_ms;
            end
            if (env_on && ppm >= regs.co_limit_tenths)
                co_on = 1'b1;
            if (co_on && pm > regs.smoke_limit)
                smoke_cnt = smoke_cnt + 3'd1;
            if (smoke_cnt == regs.smoke_target)
            begin
                smoke_cnt = 3'd0;
                smoke_on  = 1'b1;
            end
            // All three stages latched: report and start the hold-off.
            if (env_on && co_on && smoke_on)
            begin
                r.critical   = 1'b1;
                env_on       = 1'b0;
                co_on        = 1'b0;
                smoke_on     = 1'b0;
                interval_ms  = regs.normal_interval_ms;
                holdoff_on   = 1'b1;
                holdoff_from = now;
            end
        end

        r.env_alarm       = env_on;
        r.co_alarm        = co_on;
        r.smoke_count     = smoke_cnt;
        r.co_ppm_tenths   = ppm;
        r.interval_now_ms = interval_ms;
        r.holding_off     = holdoff_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PrintCap)
            $display("mismatch on status %0d: %s is %0d, expected %0d",
                     statuses_seen, what, got, want);
        fail_count++;
    endtask

    task automatic compare_status(input sfae_pkg::result_t want);
        if (status.evaluated !== want.evaluated)
            report_mismatch("evaluated", status.evaluated, want.evaluated);
        if (status.env_alarm !== want.env_alarm)
            report_mismatch("env_alarm", status.env_alarm, want.env_alarm);
        if (status.co_alarm !== want.co_alarm)
            report_mismatch("co_alarm", status.co_alarm, want.co_alarm);
        if (status.critical !== want.critical)
            report_mismatch("critical", status.critical, want.critical);
        if (status.smoke_count !== want.smoke_count)
            report_mismatch("smoke_count", status.smoke_count, want.smoke_count);
        if (status.co_ppm_tenths !== want.co_ppm_tenths)
            report_mismatch("co_ppm_tenths", status.co_ppm_tenths, want.co_ppm_tenths);
        if (status.interval_now_ms !== want.interval_now_ms)
            report_mismatch("interval_now_ms", status.interval_now_ms,
                            want.interval_now_ms);
        if (status.holding_off !== want.holding_off)
            report_mismatch("holding_off", status.holding_off, want.holding_off);
    endtask

    // Everything is sampled at the rising edge, before the block's own updates land.
    always @(posedge clk or negedge rst_n)
    begin
        sfae_pkg::result_t want;
        if (!rst_n)
        begin
            regs.temp_limit_centi     = sfae_pkg::TempLimitRst;
            regs.humidity_limit_centi = sfae_pkg::HumidityLimitRst;
            regs.co_limit_tenths      = sfae_pkg::CoLimitRst;
            regs.smoke_limit          = sfae_pkg::SmokeLimitRst;
            regs.normal_interval_ms   = sfae_pkg::NormalIntervalRst;
            regs.alert_interval_ms    = sfae_pkg::AlertIntervalRst;
            regs.holdoff_ms           = sfae_pkg::HoldoffRst;
            regs.smoke_target         = sfae_pkg::SmokeTargetRst;
            last_eval_ms  = '0;
            interval_ms   = sfae_pkg::NormalIntervalRst;
            env_on        = 1'b0;
            co_on         = 1'b0;
            smoke_on      = 1'b0;
            smoke_cnt     = '0;
            holdoff_on    = 1'b0;
            holdoff_from  = '0;
            owed_status.delete();
            statuses_seen = 0;
            fail_count    = 0;
            outstanding   = 0;
            snapshots     = 0;
            evaluations   = 0;
            criticals     = 0;
            held_off      = 0;
        end
        else
        begin
            // Register writes only happen while the block is idle.
            if (psel && penable && pwrite && pready)
            begin
                case (sfae_pkg::reg_idx_t'(paddr[sfae_pkg::CfgAddrWidth-1:2]))
                    sfae_pkg::REG_TEMP_LIMIT:
                        regs.temp_limit_centi     = pwdata[14:0];
                    sfae_pkg::REG_HUMIDITY_LIMIT:
                        regs.humidity_limit_centi = pwdata[13:0];
                    sfae_pkg::REG_CO_LIMIT:
                        regs.co_limit_tenths      = pwdata[15:0];
                    sfae_pkg::REG_SMOKE_LIMIT:
                        regs.smoke_limit          = pwdata[15:0];
                    sfae_pkg::REG_NORMAL_INTERVAL:
                        regs.normal_interval_ms   = pwdata[19:0];
                    sfae_pkg::REG_ALERT_INTERVAL:
                        regs.alert_interval_ms    = pwdata[19:0];
                    sfae_pkg::REG_HOLDOFF:
                        regs.holdoff_ms           = pwdata[19:0];
                    sfae_pkg::REG_SMOKE_TARGET:
                        regs.smoke_target         = pwdata[2:0];
                    default: ;
                endcase
            end

            // Status transfer: check against the oldest value owed.
            if (status.valid && status.ready)
            begin
                if (owed_status.size() == 0)
                    report_mismatch("status with nothing outstanding", 32'd1, 32'd0);
                else
                begin
                    compare_status(owed_status.pop_front());
                    outstanding--;
                end
                statuses_seen++;
            end

            // Sensor transfer: predict the status it must produce.
            if (sensor.valid && sensor.ready)
            begin
                want = escalate(sensor.now_ms, sensor.temperature_centi,
                                sensor.humidity_centi, sensor.co_adc_level,
                                sensor.pm25_level);
                owed_status.push_back(want);
                outstanding++;
                snapshots++;
                if (want.evaluated)
                    evaluations++;
                if (want.critical)
                    criticals++;
                if (want.holding_off && !want.evaluated)
                    held_off++;
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Staged fire alert escalation: testbench top
// Drives sensor snapshots and register writes into the block, stalls the
// status side at random and gives the verdict from the checker's count.
// A short directed sequence walks one full escalation, the hold-off, the CO
// map knees and time wrap; random phases under several register settings,
// the extremes and a zero interval among them, follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CycleLimit = 1000000;

    typedef struct {
        logic [31:0]        now_ms;
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic [11:0]        adc;
        logic [15:0]        pm;
    } snapshot_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [sfae_pkg::CfgAddrWidth-1:0] paddr;
    logic [sfae_pkg::CfgDataWidth-1:0] pwdata;
    logic [sfae_pkg::CfgDataWidth-1:0] prdata;
    logic                              pready;

    sfae_sensor_if sensor_ch ();
    sfae_status_if status_ch ();

    int          fail_count;
    int          outstanding;
    int          snapshots;
    int          evaluations;
    int          criticals;
    int          held_off;
    int unsigned cycles = 0;
    int          settings_done;

    // Register values in force, used to aim the time steps and readings
    int          t_lim;
    int unsigned h_lim;
    int unsigned s_lim;
    int unsigned norm_iv;
    int unsigned alert_iv;
    int unsigned hold_iv;
    logic [31:0] wall_ms;

    staged_fire_alert_escalation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sensor  (sensor_ch),
        .status  (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sfae_alert_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sensor      (sensor_ch),
        .status      (status_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .snapshots   (snapshots),
        .evaluations (evaluations),
        .criticals   (criticals),
        .held_off    (held_off)
    );

    always #2 clk = ~clk;

    // Watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("run stopped after %0d cycles with %0d statuses owed",
                     cycles, outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // Status side back-pressure: random stalls, with a stall-free stretch
    // recurring at regular points of the cycle count.
    initial
    begin
        int unsigned stall_left;
        status_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (cycles % 1024 < 200)
                status_ch.ready <= 1'b1;
            else if (stall_left > 0)
                stall_left--;
            else if ($urandom_range(0, 99) < 65)
            begin
                status_ch.ready <= 1'b1;
                stall_left = $urandom_range(0, 10);
            end
            else
            begin
                status_ch.ready <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    // Idle cycles before a snapshot: mostly none or few, now and then many.
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Presents one snapshot and returns at the falling edge after its transfer.
    task automatic put_item(input snapshot_t s, input int unsigned gap);
        if (gap > 0)
        begin
            sensor_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sensor_ch.valid             <= 1'b1;
        sensor_ch.now_ms            <= s.now_ms;
        sensor_ch.temperature_centi <= s.temp;
        sensor_ch.humidity_centi    <= s.hum;
        sensor_ch.co_adc_level      <= s.adc;
        sensor_ch.pm25_level        <= s.pm;
        do @(posedge clk); while (!sensor_ch.ready);
        @(negedge clk);
    endtask

    // Stops the sender and waits until every owed status has come back.
    task automatic drain_results();
        sensor_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input sfae_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes the whole register set once the block has gone quiet.
    task automatic configure(input int tl, input int unsigned hl, input int unsigned col,
                             input int unsigned sl, input int unsigned nv,
                             input int unsigned av, input int unsigned ho,
                             input int unsigned tg);
        drain_results();
        write_reg(sfae_pkg::REG_TEMP_LIMIT, 32'(tl));
        write_reg(sfae_pkg::REG_HUMIDITY_LIMIT, hl);
        write_reg(sfae_pkg::REG_CO_LIMIT, col);
        write_reg(sfae_pkg::REG_SMOKE_LIMIT, sl);
        write_reg(sfae_pkg::REG_NORMAL_INTERVAL, nv);
        write_reg(sfae_pkg::REG_ALERT_INTERVAL, av);
        write_reg(sfae_pkg::REG_HOLDOFF, ho);
        write_reg(sfae_pkg::REG_SMOKE_TARGET, tg);
        t_lim    = tl;
        h_lim    = hl;
        s_lim    = sl;
        norm_iv  = nv;
        alert_iv = av;
        hold_iv  = ho;
        settings_done++;
    endtask

    task automatic send_directed(input logic [31:0] now, input int temp,
                                 input int unsigned hum, input int unsigned adc,
                                 input int unsigned pm);
        snapshot_t s;
        s.now_ms = now;
        s.temp   = temp[14:0];
        s.hum    = hum[13:0];
        s.adc    = adc[11:0];
        s.pm     = pm[15:0];
        wall_ms  = now;
        put_item(s, pick_gap(1'b0));
    endtask

    // Next random snapshot. Fire-like snapshots lean towards readings that
    // push each stage of the escalation; time steps aim at the intervals.
    function automatic snapshot_t next_snapshot(input bit fire);
        snapshot_t   s;
        int unsigned r;
        int unsigned delta;
        int          tv;
        logic [31:0] raw;

        r = $urandom_range(0, 99);
        if (r < 35)
            delta = alert_iv + $urandom_range(0, 2);
        else if (r < 50)
            delta = norm_iv + $urandom_range(0, 2);
        else if (r < 58)
            delta = hold_iv + $urandom_range(0, 2);
        else if (r < 64)
            delta = (alert_iv > 0) ? alert_iv - 1 : 0;
        else if (r < 82)
            delta = $urandom_range(0, 50);
        else if (r < 88)
            delta = $urandom;
        else
            delta = $urandom_range(0, alert_iv);
        wall_ms  = wall_ms + delta;
        s.now_ms = wall_ms;

        r = $urandom_range(0, 99);
        if (fire && r < 45)
            tv = t_lim + int'($urandom_range(0, 40));
        else if (r < 52)
            tv = t_lim - 1;
        else if (r < 57)
            tv = $urandom;
        else
            tv = int'($urandom_range(0, 12500)) - 4000;
        s.temp = tv[14:0];

        r = $urandom_range(0, 99);
        if (fire && r < 30 && h_lim > 0)
            raw = $urandom_range(0, h_lim - 1);
        else if (r < 36)
            raw = h_lim;
        else if (r < 40)
            raw = $urandom;
        else
            raw = $urandom_range(0, 10000);
        s.hum = raw[13:0];

        r = $urandom_range(0, 99);
        if (fire && r < 65)
            raw = $urandom_range(2300, 4095);
        else
            raw = $urandom_range(0, 4095);
        s.adc = raw[11:0];

        r = $urandom_range(0, 99);
        if (fire && r < 65)
            raw = (s_lim < 65535) ? $urandom_range(s_lim + 1, 65535) : 65535;
        else if (r < 72)
            raw = s_lim;
        else
            raw = $urandom_range(0, 65535);
        s.pm = raw[15:0];
        return s;
    endfunction

    // Random traffic in chunks of fire-like or noise snapshots, with one full
    // pause half way through.
    task automatic run_random(input int unsigned count);
        int unsigned done_n;
        int unsigned chunk;
        bit          fire;
        bit          steady;
        bit          paused;
        done_n = 0;
        paused = 1'b0;
        while (done_n < count)
        begin
            chunk  = $urandom_range(15, 50);
            fire   = ($urandom_range(0, 3) != 0);
            steady = ($urandom_range(0, 4) == 0);
            while (chunk > 0 && done_n < count)
            begin
                put_item(next_snapshot(fire), pick_gap(steady));
                chunk--;
                done_n++;
            end
            if (!paused && done_n >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        int unsigned knee_adc [8];
        knee_adc = '{744, 745, 1240, 1241, 2481, 2482, 3722, 3723};

        rst_n                       = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        sensor_ch.valid             = 1'b0;
        sensor_ch.now_ms            = '0;
        sensor_ch.temperature_centi = '0;
        sensor_ch.humidity_centi    = '0;
        sensor_ch.co_adc_level      = '0;
        sensor_ch.pm25_level        = '0;
        wall_ms                     = '0;
        t_lim                       = 3500;
        h_lim                       = 3000;
        s_lim                       = 300;
        norm_iv                     = 120000;
        alert_iv                    = 30000;
        hold_iv                     = 300000;
        settings_done               = 1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Field extremes, the second one just short of the first interval.
        send_directed(32'd0, -4000, 0, 0, 0);
        send_directed(32'd119999, 8500, 10000, 4095, 65535);
        // Full escalation under the reset settings: temperature at its limit with
        // a first smoke count, then low humidity, then two more ending in critical.
        send_directed(32'd120000, 3500, 5000, 4095, 301);
        send_directed(32'd149999, 0, 5000, 100, 0);
        send_directed(32'd150000, 0, 2999, 2500, 300);
        send_directed(32'd180000, 2000, 4000, 3000, 65535);
        send_directed(32'd210000, 2000, 4000, 3000, 65535);
        // Hold-off: ignored right after, one short of the end, then released.
        send_directed(32'd210001, 8500, 0, 4095, 65535);
        send_directed(32'd509999, 8500, 0, 4095, 65535);
        send_directed(32'd510000, -1, 5000, 0, 0);
        // CO map knees, either side of each break point.
        foreach (knee_adc[i])
            send_directed(32'd510001 + i, 2000, 5000, knee_adc[i], 0);
        // Time stamp wrap across two to the 32.
        send_directed(32'hFFFF_FFF0, 0, 5000, 2000, 0);
        send_directed(32'h0001_D4B0, 0, 5000, 2000, 0);

        run_random(240);
        // Low extremes, with a humidity limit of 10000 that most snapshots fall under.
        configure(-4000, 10000, 50, 0, 1, 1, 0, 1);
        run_random(240);
        // High extremes.
        configure(8500, 0, 50000, 65535, 1048575, 1048575, 1048575, 7);
        run_random(240);
        // Zero intervals and a zero smoke target.
        configure(3000, 2500, 200, 100, 0, 0, $urandom_range(0, 5000), 0);
        run_random(240);
        repeat (2)
        begin
            configure(int'($urandom_range(0, 12500)) - 4000, $urandom_range(0, 10000),
                      $urandom_range(50, 50000), $urandom_range(0, 3000),
                      $urandom_range(1, 200000), $urandom_range(1, 50000),
                      $urandom_range(0, 400000), $urandom_range(1, 7));
            run_random(245);
        end
        drain_results();

        $display("covered %0d snapshots under %0d register settings", snapshots,
                 settings_done);
        $display("%0d evaluations, %0d critical events, %0d snapshots held off",
                 evaluations, criticals, held_off);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
